// ===== rtl/ksr_pkg.sv =====
// ksr_pkg: shared types, codes and field widths for the kth-present select block
// no dependencies; imported by the engine and the top level

package ksr_pkg;

  // field widths of the stream items
  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int POS_W = 11;

  // stream bus data widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((IDX_W + VAL_W + POS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((IDX_W + VAL_W + 7) / 8) * 8;

  // default number of slots
  localparam int SLOTS_DEF = 1024;

  // request kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // result status codes
  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LD_CHECK,
    ST_LD_WALK,
    ST_RM_ROOT,
    ST_RM_WALK,
    ST_RM_VAL,
    ST_FINISH
  } ksr_state_t;

  // one request as seen by the engine
  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] slot_index;
    logic [VAL_W-1:0] slot_value;
    logic [POS_W-1:0] position;
  } ksr_item_t;

  // one result as produced by the engine
  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] found_index;
    logic [VAL_W-1:0] found_value;
  } ksr_result_t;

endpackage

// ===== rtl/ksr_ram.sv =====
// ksr_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module ksr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/ksr_engine.sv =====
// ksr_engine: sequencer and shared compare/add unit walking the present-count tree
// depends on ksr_pkg and ksr_ram (count tree memory and slot value memory)

module ksr_engine
  import ksr_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  output logic        req_ready,
  input  ksr_item_t   req,
  output logic        res_valid,
  input  logic        res_ready,
  output ksr_result_t res
);

  // tree geometry: LV levels below the root, leaves at 2**LV + slot
  localparam int LV = $clog2(SLOTS);
  localparam int NW = LV + 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int XW = ((LV > IDX_W) ? LV : IDX_W) + 1;
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [NW-1:0] ROOT_ADDR = NW'(1);
  localparam logic [NW-1:0] ROOT_LEFT = NW'(2);

  ksr_state_t state_r, state_nxt;

  logic [NW-1:0]    clr_r;
  logic [NW-1:0]    node_r;
  logic [LV-1:0]    path_r;
  logic [CW-1:0]    rank_r;
  logic [CW-1:0]    cur_r;
  logic [POS_W-1:0] pos_r;
  logic             status_r;
  logic [IDX_W-1:0] fidx_r;
  logic [VAL_W-1:0] fval_r;

  // memory ports
  logic          cnt_we;
  logic [NW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;
  logic [NW-1:0] cnt_raddr;
  logic [CW-1:0] cnt_rdata;
  logic          val_we;
  logic [LV-1:0] val_waddr;
  logic [LV-1:0] val_raddr;
  logic [VAL_W-1:0] val_rdata;

  // shared unit signals
  logic [XW-1:0] sidx_x;
  logic          sidx_ok;
  logic [LV-1:0] slot_in;
  logic          go_left;
  logic [NW-1:0] child;
  logic [CW-1:0] child_cnt;
  logic          child_leaf;
  logic [NW-1:0] ld_next;
  logic          rm_bad;

  ksr_ram #(.WIDTH(CW), .DEPTH(2 ** NW)) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (cnt_waddr),
    .wr_data (cnt_wdata),
    .rd_addr (cnt_raddr),
    .rd_data (cnt_rdata)
  );

  ksr_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_val_ram (
    .clk     (clk),
    .wr_en   (val_we),
    .wr_addr (val_waddr),
    .wr_data (req.slot_value),
    .rd_addr (val_raddr),
    .rd_data (val_rdata)
  );

  // request slot range check
  assign sidx_x  = XW'(req.slot_index);
  assign sidx_ok = sidx_x < XW'(SLOTS);
  assign slot_in = sidx_x[LV-1:0];

  // descent step: compare rank against the left child count
  assign go_left    = rank_r < cnt_rdata;
  assign child      = {node_r[LV-1:0], ~go_left};
  assign child_cnt  = go_left ? cnt_rdata : cur_r - cnt_rdata;
  assign child_leaf = child[LV];

  // load walk follows the slot bits from the top
  assign ld_next = {node_r[LV-1:0], path_r[LV-1]};

  // rank must lie in 1..root count
  assign rm_bad = (pos_r == '0) || (PW'(pos_r) > PW'(cnt_rdata));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          if (req.kind == KIND_REMOVE) state_nxt = ST_RM_ROOT;
          else if (sidx_ok)            state_nxt = ST_LD_CHECK;
          else                         state_nxt = ST_FINISH;
        end
      end
      ST_LD_CHECK: begin
        state_nxt = (cnt_rdata != '0) ? ST_FINISH : ST_LD_WALK;
      end
      ST_LD_WALK: begin
        if (node_r[LV]) state_nxt = ST_FINISH;
      end
      ST_RM_ROOT: begin
        state_nxt = rm_bad ? ST_FINISH : ST_RM_WALK;
      end
      ST_RM_WALK: begin
        if (child_leaf) state_nxt = ST_RM_VAL;
      end
      ST_RM_VAL: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = node_r;
    cnt_wdata = '0;
    cnt_raddr = ROOT_ADDR;
    val_we    = 1'b0;
    val_waddr = slot_in;
    val_raddr = child[LV-1:0];
    case (state_r)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req.kind == KIND_LOAD) begin
          cnt_raddr = {1'b1, slot_in};
          val_we    = req_valid && sidx_ok;
        end
      end
      ST_LD_CHECK: begin
        cnt_raddr = ROOT_ADDR;
      end
      ST_LD_WALK: begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_rdata + CW'(1);
        cnt_raddr = ld_next;
      end
      ST_RM_ROOT: begin
        cnt_we    = !rm_bad;
        cnt_waddr = ROOT_ADDR;
        cnt_wdata = cnt_rdata - CW'(1);
        cnt_raddr = ROOT_LEFT;
      end
      ST_RM_WALK: begin
        cnt_we    = 1'b1;
        cnt_waddr = child;
        cnt_wdata = child_cnt - CW'(1);
        cnt_raddr = {child[LV-1:0], 1'b0};
      end
      ST_RM_VAL: begin
        cnt_we = 1'b0;
      end
      ST_FINISH: begin
        res_valid = 1'b1;
      end
      default: begin
        cnt_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + NW'(1);
    end
  end

  // walk and result registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        node_r   <= ROOT_ADDR;
        path_r   <= slot_in;
        pos_r    <= req.position;
        status_r <= STATUS_DONE;
        fidx_r   <= '0;
        fval_r   <= '0;
      end
      ST_LD_WALK: begin
        node_r <= ld_next;
        path_r <= path_r << 1;
      end
      ST_RM_ROOT: begin
        rank_r <= CW'(pos_r - POS_W'(1));
        cur_r  <= cnt_rdata;
        if (rm_bad) status_r <= STATUS_RANGE;
      end
      ST_RM_WALK: begin
        node_r <= child;
        cur_r  <= child_cnt;
        if (!go_left) rank_r <= rank_r - cnt_rdata;
        if (child_leaf) fidx_r <= IDX_W'(child[LV-1:0]);
      end
      ST_RM_VAL: begin
        fval_r <= val_rdata;
      end
      default: begin
        fval_r <= fval_r;
      end
    endcase
  end

  assign res.status      = status_r;
  assign res.found_index = fidx_r;
  assign res.found_value = fval_r;

`ifndef SYNTHESIS
  // the chosen child on a remove always holds at least one present slot
  a_rm_child_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RM_WALK) |-> (child_cnt != '0))
    else $error("remove descent entered an empty subtree");

  // a load walk only runs while some slot is still absent
  a_ld_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LD_WALK) |-> (cnt_rdata < CW'(SLOTS)))
    else $error("load walk would overflow a count");

  // count updates never collide with the read of the next level
  a_cnt_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_we && state_r != ST_CLEAR) |-> (cnt_waddr != cnt_raddr))
    else $error("count write and read hit the same node");

  // a remove reaches its leaf in the cycle before the value is taken
  a_val_after_leaf: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RM_WALK && child_leaf) |=> (state_r == ST_RM_VAL))
    else $error("value fetch did not follow the leaf");
`endif

endmodule

// ===== rtl/kth_present_select_and_remove.sv =====
// Usage:
//   A table of SLOTS slots, each with a 32-bit value and a presence mark, plus
//   a present-count tree kept in a memory of 2 * 2**clog2(SLOTS) entries.
//   in_* stream: in_tuser = kind (0 load, 1 remove); in_tdata carries
//   slot_index, slot_value and position. A load stores the value and marks
//   the slot present; a remove picks the slot at the given 1-based rank among
//   present slots, returns it and marks it absent.
//   out_* stream: out_tuser = status (1 = rank out of range), out_tdata
//   carries found_index and found_value. Exactly one result per request.
// Sequencing (tree depth L = clog2(SLOTS), 10 by default):
//   one request at a time; in_tready is high only while the sequencer idles.
//   remove: root range check, then L levels of descent at one tree level per
//   cycle, then the value read. Load to an absent slot: presence check, then a
//   count walk from root to leaf; present slot or rejected remove: check only;
//   slot out of range: none. The count memory gives one read and one write per cycle.
// Reset: a clearing pass zeroes all 2 * 2**L (2048 by default) count memory entries,
//   with in_tready low. Slot values are not cleared.
// Stall: the result sits in an output register; the engine holds its next
//   result until that register frees up, so nothing is dropped.

module kth_present_select_and_remove
  import ksr_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // slot_index, slot_value, position, zero pad
  input  logic                   in_tuser,   // kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // found_index, found_value, zero pad
  output logic                   out_tuser   // status
);

  ksr_item_t   item;
  ksr_result_t res;
  logic        res_valid;
  logic        res_ready;

  logic        out_valid_r;
  ksr_result_t out_r;

  // unpack the request
  assign item.kind       = in_tuser;
  assign item.slot_index = in_tdata[IDX_W-1:0];
  assign item.slot_value = in_tdata[IDX_W+VAL_W-1:IDX_W];
  assign item.position   = in_tdata[IDX_W+VAL_W+POS_W-1:IDX_W+VAL_W];

  ksr_engine #(.SLOTS(SLOTS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req_ready (in_tready),
    .req       (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // output register
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  // pack the result
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = OUT_TDATA_W'({out_r.found_value, out_r.found_index});

endmodule

// ===== tb/sv/kth_present_select_and_remove_tb.sv =====
// testbench for kth_present_select_and_remove: load and rank-remove requests checked
// against a presence/value table kept in the bench; depends on ksr_pkg and the rtl top

module kth_present_select_and_remove_tb;
  import ksr_pkg::*;

  localparam int NUM_SLOTS   = SLOTS_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PAD_W       = IN_TDATA_W - IDX_W - VAL_W - POS_W;
  localparam int DRAIN_CYCLES = 40;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // slot_index, slot_value, position, zero pad
  logic                   in_tuser;   // kind
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // found_index, found_value, zero pad
  logic                   out_tuser;  // status

  // bench copy of the slot table
  bit               slot_live [NUM_SLOTS];
  logic [VAL_W-1:0] slot_store [NUM_SLOTS];
  int               live_count;

  ksr_result_t pending_results [$];
  int          mismatch_count;
  int          cycles;
  int          ready_left;

  kth_present_select_and_remove #(
    .SLOTS(NUM_SLOTS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 12-unit clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // apply one request to the table and return the result it should produce
  function automatic ksr_result_t apply_request(input logic kind, input logic [IDX_W-1:0] idx,
                                                input logic [VAL_W-1:0] val,
                                                input logic [POS_W-1:0] pos);
    ksr_result_t res;
    int          rank;
    bit          hit;
    res = '0;
    res.status = STATUS_DONE;
    if (kind == KIND_LOAD) begin
      slot_store[idx] = val;
      if (!slot_live[idx]) begin
        slot_live[idx] = 1'b1;
        live_count++;
      end
    end else if (pos == '0 || int'(pos) > live_count) begin
      res.status = STATUS_RANGE;
    end else begin
      // walk the live slots in index order down to the requested rank
      rank = int'(pos);
      hit  = 1'b0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (!hit && slot_live[s]) begin
          rank--;
          if (rank == 0) begin
            hit = 1'b1;
            res.found_index = IDX_W'(s);
            res.found_value = slot_store[s];
            slot_live[s] = 1'b0;
            live_count--;
          end
        end
      end
    end
    return res;
  endfunction

  // idle gap before a request: mostly none or short, sometimes long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one request and record its expected result on acceptance
  task automatic send_request(input logic kind, input logic [IDX_W-1:0] idx,
                              input logic [VAL_W-1:0] val, input logic [POS_W-1:0] pos);
    int          gap;
    ksr_result_t exp_res;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{PAD_W{1'b0}}, pos, val, idx};
    do @(posedge clk); while (!in_tready);
    exp_res = apply_request(kind, idx, val, pos);
    pending_results = {pending_results, exp_res};
  endtask

  task automatic send_load(input int idx, input logic [VAL_W-1:0] val);
    send_request(KIND_LOAD, IDX_W'(idx), val, POS_W'($urandom_range(0, NUM_SLOTS)));
  endtask

  task automatic send_remove(input int pos);
    send_request(KIND_REMOVE, IDX_W'($urandom_range(0, NUM_SLOTS - 1)), VAL_W'($urandom()),
                 POS_W'(pos));
  endtask

  // rank requests against an empty table
  task automatic test_empty_remove();
    send_remove(0);
    send_remove(1);
    send_remove(NUM_SLOTS);
  endtask

  // loads at the index and value extremes, plus rewrites of live slots
  task automatic test_load_extremes();
    send_load(0, '0);
    send_load(NUM_SLOTS - 1, '1);
    send_load(NUM_SLOTS / 2, 32'hA5A5_A5A5);
    send_load(0, 32'h5A5A_5A5A);
    send_load(NUM_SLOTS - 1, '1);
  endtask

  // rank zero, rank one past the count, last, first, then drain to empty
  task automatic test_remove_extremes();
    send_remove(0);
    send_remove(live_count + 1);
    send_remove(live_count);
    send_remove(1);
    send_remove(1);
    send_remove(1);
  endtask

  // every slot loaded, shuffled; removes at top rank, one past it, top again, first
  task automatic test_fill_all();
    int order [NUM_SLOTS];
    int j;
    int tmp;
    for (int i = 0; i < NUM_SLOTS; i++) order[i] = i;
    for (int i = NUM_SLOTS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < NUM_SLOTS; i++) send_load(order[i], VAL_W'($urandom()));
    send_remove(NUM_SLOTS);
    send_remove(NUM_SLOTS);
    send_remove(live_count);
    send_remove(1);
  endtask

  // mixed loads and removes, mostly valid ranks, some out-of-range noise
  task automatic test_random_mix(input int count);
    int roll;
    int load_share;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      load_share = (live_count > NUM_SLOTS / 2) ? 35 : 55;
      if (roll < 8) begin
        case ($urandom_range(0, 2))
          0: send_remove(0);
          1: send_remove(live_count + 1);
          default: send_remove($urandom_range(0, NUM_SLOTS));
        endcase
      end else if (live_count == 0 || roll < 8 + load_share) begin
        send_load($urandom_range(0, NUM_SLOTS - 1), VAL_W'($urandom()));
      end else begin
        send_remove($urandom_range(1, live_count));
      end
    end
  endtask

  // result side backpressure: short and long stalls, with long free-running stretches
  always @(posedge clk) begin
    if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else if (out_tready) begin
      out_tready <= 1'b0;
      ready_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
      ready_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(0, 6);
    end
  end

  // compare each accepted result with the oldest pending one
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d index %0d value %0h", out_tuser,
               out_tdata[IDX_W-1:0], out_tdata[IDX_W+VAL_W-1:IDX_W]);
        mismatch_count++;
      end else begin
        if (out_tuser !== pending_results[0].status) begin
          $error("status: expected %0d, got %0d", pending_results[0].status, out_tuser);
          mismatch_count++;
        end
        if (out_tdata[IDX_W-1:0] !== pending_results[0].found_index) begin
          $error("found_index: expected %0d, got %0d", pending_results[0].found_index,
                 out_tdata[IDX_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[IDX_W+VAL_W-1:IDX_W] !== pending_results[0].found_value) begin
          $error("found_value: expected %0h, got %0h", pending_results[0].found_value,
                 out_tdata[IDX_W+VAL_W-1:IDX_W]);
          mismatch_count++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // reset, tests in turn, drain, verdict
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = KIND_LOAD;
    in_tdata   = '0;
    out_tready = 1'b1;
    ready_left = 0;
    live_count = 0;
    mismatch_count = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_live[i]  = 1'b0;
      slot_store[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_remove();
    test_load_extremes();
    test_remove_extremes();
    test_fill_all();
    test_random_mix(780);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ksr_pkg.sv
rtl/ksr_ram.sv
rtl/ksr_engine.sv
rtl/kth_present_select_and_remove.sv
tb/sv/kth_present_select_and_remove_tb.sv
